// ===== hdl/set_assoc_lru_tag_lookup_core_macros.svh =====
// Assertion macros used by the tag lookup core.
`ifndef SET_ASSOC_LRU_TAG_LOOKUP_CORE_MACROS_SVH
`define SET_ASSOC_LRU_TAG_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SALTL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tag lookup: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SALTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tag lookup: next-cycle check failed");

`endif

// ===== hdl/saltl_pkg.sv =====
package saltl_pkg;

  localparam int WAYS      = 4;
  localparam int SETS      = 256;
  localparam int ADDR_BITS = 48;

  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 32;
  localparam int WAY_OUT_W = 2;

  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SHAMT_W = CFG_W + 1;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_OFS_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IDX_WIDTH = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] OFS_WIDTH_RST = CFG_W'(6);
  localparam logic [CFG_W-1:0] IDX_WIDTH_RST = CFG_W'(8);
  // floor(log2(SETS)): widest set index that still names an existing set
  localparam logic [CFG_W-1:0] MAX_IDX_WIDTH = CFG_W'($clog2(SETS + 1) - 1);

  typedef struct packed {
    logic [WAYS-1:0]                valid;
    logic [WAYS-1:0][ADDR_BITS-1:0] tag;
    logic [WAYS-1:0][WAY_W-1:0]     age;
  } row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    row_t             row;
  } lookup_t;

  function automatic row_t reset_row();
    row_t r;
    r.valid = '0;
    r.tag   = '0;
    for (int w = 0; w < WAYS; w++) begin
      r.age[w] = WAY_W'(w);
    end
    return r;
  endfunction

endpackage

// ===== hdl/saltl_set_store.sv =====
module saltl_set_store (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [saltl_pkg::SET_W-1:0] rd_set,
  input  logic                    wr_en,
  input  logic [saltl_pkg::SET_W-1:0] wr_set,
  input  saltl_pkg::row_t         wr_row,
  output saltl_pkg::row_t         rd_row
);
  import saltl_pkg::*;

  row_t            mem [SETS];
  logic [SETS-1:0] touched;
  row_t            rd_raw;
  logic            rd_touched;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_raw     <= mem[rd_set];
      rd_touched <= touched[rd_set];
    end
  end

  // One bit per set: a set never written reads as its reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
    end else if (wr_en) begin
      touched[wr_set] <= 1'b1;
    end
  end

  assign rd_row = rd_touched ? rd_raw : reset_row();

endmodule

// ===== hdl/saltl_way_select.sv =====
module saltl_way_select (
  input  saltl_pkg::row_t                    row,
  input  logic [saltl_pkg::ADDR_BITS-1:0]    tag,
  output saltl_pkg::lookup_t                 res
);
  import saltl_pkg::*;

  logic             hit_any;
  logic [WAY_W-1:0] hit_way;
  logic             inv_any;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] best;
  logic [WAY_W-1:0] max_way;
  logic [WAY_W-1:0] chosen;
  logic [WAY_W-1:0] old_age;

  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    best    = '0;
    max_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && row.valid[w] && row.tag[w] == tag) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!inv_any && !row.valid[w]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(w);
      end
      // ties go to the later way
      if (row.age[w] >= best) begin
        best    = row.age[w];
        max_way = WAY_W'(w);
      end
    end

    priority if (hit_any) begin
      chosen = hit_way;
    end else if (inv_any) begin
      chosen = inv_way;
    end else begin
      chosen = max_way;
    end
    old_age = row.age[chosen];

    res.hit = hit_any;
    res.way = chosen;
    res.row = row;
    if (!hit_any) begin
      res.row.valid[chosen] = 1'b1;
      res.row.tag[chosen]   = tag;
    end
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == chosen) begin
        res.row.age[w] = '0;
      end else if (row.age[w] < old_age) begin
        res.row.age[w] = row.age[w] + WAY_W'(1);
      end
    end
  end

endmodule

// ===== hdl/set_assoc_lru_tag_lookup_core.sv =====
// Four-way set-associative tag store with true LRU, one access per clock.
// An access is taken at every edge where start is high; busy never rises.
// Its result shows on hit, way_used, hit_total and miss_total with done high
// for one cycle, once the access has passed vld_s1 and vld_s2 and done is
// registered. The receiver cannot stall, so results leave at the input
// rate. The set rows live in a single-port-read, single-port-write memory;
// the read of one access and the write-back of the one before are bridged by
// a forwarding register, so accesses to the same set may follow back to back.
// Sets never written read as reset contents through per-set flags, so no
// clearing pass follows reset. Write ofs_width and idx_width only while
// no access is in flight.
`include "set_assoc_lru_tag_lookup_core_macros.svh"

module set_assoc_lru_tag_lookup_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [saltl_pkg::ADDR_BITS-1:0]     address,
  input  logic                                wr_en,
  input  logic [saltl_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [saltl_pkg::CFG_W-1:0]         wr_data,
  output logic                                done,
  output logic                                hit,
  output logic [saltl_pkg::WAY_OUT_W-1:0]     way_used,
  output logic [saltl_pkg::CNT_W-1:0]         hit_total,
  output logic [saltl_pkg::CNT_W-1:0]         miss_total
);
  import saltl_pkg::*;

  logic [CFG_W-1:0]     ofs_width;
  logic [CFG_W-1:0]     idx_width;

  logic                 vld_s1;
  logic [ADDR_BITS-1:0] addr_s1;
  logic [CFG_W-1:0]     ib_eff;
  logic [SHAMT_W-1:0]   tag_shift;
  logic [ADDR_BITS-1:0] set_mask;
  logic [ADDR_BITS-1:0] set_full;
  logic [SET_W-1:0]     set_s1;
  logic [ADDR_BITS-1:0] tag_s1;

  logic                 vld_s2;
  logic [SET_W-1:0]     set_s2;
  logic [ADDR_BITS-1:0] tag_s2;
  row_t                 mem_row;
  row_t                 row_s2;

  logic                 fwd_vld;
  logic [SET_W-1:0]     fwd_set;
  row_t                 fwd_row;

  lookup_t              lk;
  logic                 way_landed;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ofs_width <= OFS_WIDTH_RST;
      idx_width <= IDX_WIDTH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OFS_WIDTH: ofs_width <= wr_data;
        REG_IDX_WIDTH: idx_width <= wr_data;
        default: ;
      endcase
    end
  end

  // Stage 1: split the address and read the set row
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1 <= 1'b0;
    end else begin
      vld_s1 <= start && !busy;
    end
    addr_s1 <= address;
  end

  assign ib_eff    = (idx_width > MAX_IDX_WIDTH) ? MAX_IDX_WIDTH : idx_width;
  assign tag_shift = SHAMT_W'(ofs_width) + SHAMT_W'(ib_eff);
  assign set_mask  = (ADDR_BITS'(1) << ib_eff) - ADDR_BITS'(1);
  assign set_full  = (addr_s1 >> ofs_width) & set_mask;
  assign set_s1    = set_full[SET_W-1:0];
  assign tag_s1    = addr_s1 >> tag_shift;

  saltl_set_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (vld_s1),
    .rd_set (set_s1),
    .wr_en  (vld_s2),
    .wr_set (set_s2),
    .wr_row (lk.row),
    .rd_row (mem_row)
  );

  // Stage 2: compare, pick the way, update ages, write back
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s2  <= 1'b0;
      fwd_vld <= 1'b0;
    end else begin
      vld_s2  <= vld_s1;
      fwd_vld <= vld_s2;
    end
    set_s2  <= set_s1;
    tag_s2  <= tag_s1;
    fwd_set <= set_s2;
    fwd_row <= lk.row;
  end

  // The memory read raced the previous write-back; take the fresh row instead
  assign row_s2 = (fwd_vld && fwd_set == set_s2) ? fwd_row : mem_row;

  saltl_way_select u_select (
    .row (row_s2),
    .tag (tag_s2),
    .res (lk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else begin
      done <= vld_s2;
      if (vld_s2) begin
        if (lk.hit) begin
          hit_total <= hit_total + CNT_W'(1);
        end else begin
          miss_total <= miss_total + CNT_W'(1);
        end
      end
    end
    hit      <= lk.hit;
    way_used <= WAY_OUT_W'(lk.way);
  end

  assign way_landed = lk.row.valid[lk.way] && lk.row.tag[lk.way] == tag_s2 &&
                      lk.row.age[lk.way] == '0;

  `SALTL_ASSERT_NEXT(a_result_follows, clk, rst, vld_s2, done)
  `SALTL_ASSERT_IMP(a_done_from_s2, clk, rst, done, $past(vld_s2))
  `SALTL_ASSERT_IMP(a_way_lands, clk, rst, vld_s2, way_landed)
  `SALTL_ASSERT_IMP(a_hit_keeps_miss, clk, rst, done && hit, miss_total == $past(miss_total))
  `SALTL_ASSERT_IMP(a_miss_keeps_hit, clk, rst, done && !hit, hit_total == $past(hit_total))

endmodule
